// File: rtl/ssps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssps_pkg
// Shared types and constants for the sequence store with push, pop, dumps
// and linear search.
// ----------------------------------------------------------------------------
package ssps_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int DATA_W    = 32;
    localparam int POS_W     = 7;
    localparam int ACT_W     = 3;
    localparam int STAT_W    = 3;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH     = 3'd0,
        ACT_POP      = 3'd1,
        ACT_DUMP_FWD = 3'd2,
        ACT_DUMP_REV = 3'd3,
        ACT_SEARCH   = 3'd4
    } act_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_DONE      = 3'd0,
        STAT_EMPTY     = 3'd1,
        STAT_FULL      = 3'd2,
        STAT_FOUND     = 3'd3,
        STAT_NOT_FOUND = 3'd4,
        STAT_LISTED    = 3'd5
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_SCAN = 1'b1
    } state_t;

    // One result beat as it leaves the controller
    typedef struct packed {
        status_t                   status;
        logic signed [DATA_W-1:0]  value;
        logic        [POS_W-1:0]   pos;
        logic                      last;
    } res_t;

endpackage

// File: rtl/sequence_store_push_pop_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequence_store_push_pop_search
// Bounded stack of signed 32-bit values with forward/reverse dump and
// linear search from the head, built around one synchronous element store.
// ----------------------------------------------------------------------------
// Push and pop: one result beat, registered in the cycle after the input beat.
// Dump of n elements: the scan state, the store read and the result register
// come before the first listed beat, then one per cycle as the output takes them.
// Search: one store read per cycle over the stored elements. The next input
// beat is taken once the item has finished. Reset clears the element count,
// the scan state and the output valid; store contents are not cleared.
module sequence_store_push_pop_search #(
    parameter int DEPTH = ssps_pkg::DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [ssps_pkg::ACT_W-1:0]         action,
    input  logic signed [ssps_pkg::DATA_W-1:0] value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [ssps_pkg::STAT_W-1:0]        status,
    output logic signed [ssps_pkg::DATA_W-1:0] element_value,
    output logic [ssps_pkg::POS_W-1:0]         position,
    output logic                               last_flag
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic                         out_valid_reg, out_valid_next;
    ssps_pkg::res_t               res_reg;
    ssps_pkg::res_t               res;
    logic                         res_load;
    logic                         slot_free;
    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    logic [ssps_pkg::DATA_W-1:0]  wr_data;
    logic                         rd_en;
    logic [AW-1:0]                rd_addr;
    logic [ssps_pkg::DATA_W-1:0]  rd_data;

    assign slot_free = !out_valid_reg || out_ready;

    ssps_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .value     (value),
        .slot_free (slot_free),
        .res_load  (res_load),
        .res       (res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    ssps_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Output beat valid: set on load, drop when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the output payload until the beat is taken
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = res_reg.status;
    assign element_value = res_reg.value;
    assign position      = res_reg.pos;
    assign last_flag     = res_reg.last;

endmodule

// File: rtl/ssps_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssps_mem
// Element store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ssps_mem #(
    parameter int DEPTH = ssps_pkg::DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [ssps_pkg::DATA_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [AW-1:0]               rd_addr,
    output logic [ssps_pkg::DATA_W-1:0] rd_data
);

    logic [ssps_pkg::DATA_W-1:0] mem [DEPTH];
    logic [ssps_pkg::DATA_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port: hold data between reads
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/ssps_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssps_ctrl
// Sequencer: executes push and pop on the count, walks the store one read
// per cycle for dumps and search unless held by a busy output slot, and produces result beats.
// ----------------------------------------------------------------------------
module ssps_ctrl #(
    parameter int DEPTH = ssps_pkg::DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [ssps_pkg::ACT_W-1:0]         action,
    input  logic signed [ssps_pkg::DATA_W-1:0] value,
    input  logic                               slot_free,
    output logic                               res_load,
    output ssps_pkg::res_t                     res,
    output logic                               wr_en,
    output logic [AW-1:0]                      wr_addr,
    output logic [ssps_pkg::DATA_W-1:0]        wr_data,
    output logic                               rd_en,
    output logic [AW-1:0]                      rd_addr,
    input  logic [ssps_pkg::DATA_W-1:0]        rd_data
);

    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    ssps_pkg::state_t                  state_reg, state_next;
    ssps_pkg::act_t                    op_reg, op_next;
    logic [ssps_pkg::DATA_W-1:0]       key_reg, key_next;
    logic [CW-1:0]                     count_reg, count_next;
    logic [CW-1:0]                     issue_reg, issue_next;
    logic                              pend_reg, pend_next;
    logic [ssps_pkg::POS_W-1:0]        pend_pos_reg, pend_pos_next;
    logic                              pend_last_reg, pend_last_next;

    logic                              accept;
    logic                              consume;
    logic                              finish;
    logic                              match;
    logic [CW-1:0]                     rev_idx;
    logic [AW-1:0]                     scan_addr;

    assign in_ready = (state_reg == ssps_pkg::S_IDLE) && slot_free;
    assign accept   = in_valid && in_ready;
    assign match    = (rd_data == key_reg);
    assign rev_idx  = count_reg - issue_reg - CW'(1);
    assign scan_addr = (op_reg == ssps_pkg::ACT_DUMP_REV) ? rev_idx[AW-1:0]
                                                          : issue_reg[AW-1:0];
    assign wr_addr  = count_reg[AW-1:0];
    assign wr_data  = value;
    assign rd_addr  = scan_addr;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ssps_pkg::S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    // Scan payload registers
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        key_reg       <= key_next;
        issue_reg     <= issue_next;
        pend_pos_reg  <= pend_pos_next;
        pend_last_reg <= pend_last_next;
    end

    // Next state, memory requests and result beats
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        count_next     = count_reg;
        issue_next     = issue_reg;
        pend_next      = pend_reg;
        pend_pos_next  = pend_pos_reg;
        pend_last_next = pend_last_reg;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        res_load       = 1'b0;
        res            = '0;
        res.last       = 1'b1;
        consume        = 1'b0;
        finish         = 1'b0;

        case (state_reg)
            ssps_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    case (ssps_pkg::act_t'(action))
                        ssps_pkg::ACT_PUSH:
                        begin
                            res_load = 1'b1;
                            if (count_reg == FULL_CNT)
                            begin
                                res.status = ssps_pkg::STAT_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CW'(1);
                                res.status = ssps_pkg::STAT_DONE;
                            end
                        end
                        ssps_pkg::ACT_POP:
                        begin
                            res_load = 1'b1;
                            if (count_reg == '0)
                            begin
                                res.status = ssps_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - CW'(1);
                                res.status = ssps_pkg::STAT_DONE;
                            end
                        end
                        ssps_pkg::ACT_DUMP_FWD, ssps_pkg::ACT_DUMP_REV,
                        ssps_pkg::ACT_SEARCH:
                        begin
                            if (count_reg == '0)
                            begin
                                res_load   = 1'b1;
                                res.status = ssps_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                state_next = ssps_pkg::S_SCAN;
                                op_next    = ssps_pkg::act_t'(action);
                                key_next   = value;
                                issue_next = '0;
                                pend_next  = 1'b0;
                            end
                        end
                        default:
                        begin
                            // drop unused codes without a result
                        end
                    endcase
                end
            end
            ssps_pkg::S_SCAN:
            begin
                // Retire the element whose read data is back
                if (pend_reg)
                begin
                    if (op_reg == ssps_pkg::ACT_SEARCH)
                    begin
                        if (match || pend_last_reg)
                        begin
                            if (slot_free)
                            begin
                                consume  = 1'b1;
                                finish   = 1'b1;
                                res_load = 1'b1;
                                if (match)
                                begin
                                    res.status = ssps_pkg::STAT_FOUND;
                                    res.pos    = pend_pos_reg;
                                end
                                else
                                begin
                                    res.status = ssps_pkg::STAT_NOT_FOUND;
                                end
                            end
                        end
                        else
                        begin
                            consume = 1'b1;
                        end
                    end
                    else if (slot_free)
                    begin
                        consume    = 1'b1;
                        finish     = pend_last_reg;
                        res_load   = 1'b1;
                        res.status = ssps_pkg::STAT_LISTED;
                        res.value  = rd_data;
                        res.pos    = pend_pos_reg;
                        res.last   = pend_last_reg;
                    end
                end

                // Issue the next read while the pending slot empties
                if (finish)
                begin
                    state_next = ssps_pkg::S_IDLE;
                    pend_next  = 1'b0;
                end
                else if ((issue_reg < count_reg) && (!pend_reg || consume))
                begin
                    rd_en          = 1'b1;
                    issue_next     = issue_reg + CW'(1);
                    pend_next      = 1'b1;
                    pend_pos_next  = {{(ssps_pkg::POS_W - AW){1'b0}}, scan_addr}
                                     + ssps_pkg::POS_W'(1);
                    pend_last_next = ((issue_reg + CW'(1)) == count_reg);
                end
                else if (consume)
                begin
                    pend_next = 1'b0;
                end
            end
            default:
            begin
                state_next = ssps_pkg::S_IDLE;
            end
        endcase
    end

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("element count above depth");

    a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (state_reg == ssps_pkg::S_SCAN) && (issue_reg < count_reg))
        else $error("store read outside a scan");

    a_write_on_push: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> accept && (count_reg != FULL_CNT))
        else $error("store write without an accepted push");

    a_load_slot: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> slot_free)
        else $error("result loaded into a busy output slot");

    a_count_stable_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ssps_pkg::S_SCAN) |=> $stable(count_reg))
        else $error("element count changed during a scan");

endmodule

// File: tb/sv/sequence_store_push_pop_search_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequence_store_push_pop_search_test
// Self-checking bench for the bounded stack with dumps and linear search.
// A short stimulus table covers the empty store, the data extremes,
// every action and the unused codes. Random rounds of fills, drains, dumps
// and searches follow. Every result beat is checked field by field against
// a shadow stack kept inside the bench, or against the table status for typed rows.
// ----------------------------------------------------------------------------
module sequence_store_push_pop_search_test;

    localparam int DEPTH       = ssps_pkg::DEPTH_DEF;
    localparam int DATA_W      = ssps_pkg::DATA_W;
    localparam int ACT_W       = ssps_pkg::ACT_W;
    localparam int STAT_W      = ssps_pkg::STAT_W;
    localparam int POS_W       = ssps_pkg::POS_W;
    localparam int TOTAL_ITEMS = 260;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 2 * DEPTH + 16;

    // Action codes the block ignores
    localparam logic [ACT_W-1:0] ACT_UNUSED_5 = 3'd5;
    localparam logic [ACT_W-1:0] ACT_UNUSED_6 = 3'd6;
    localparam logic [ACT_W-1:0] ACT_UNUSED_7 = 3'd7;

    localparam logic signed [DATA_W-1:0] MAX_POS = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] MIN_NEG = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] ALL_ONE = 32'shFFFF_FFFF;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic [ACT_W-1:0]         action;
    logic signed [DATA_W-1:0] value;
    logic                     out_valid;
    logic                     out_ready;
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] element_value;
    logic [POS_W-1:0]         position;
    logic                     last_flag;

    // Stimulus table row: typed rows carry their single result status
    typedef struct {
        logic [ACT_W-1:0]         act;
        logic signed [DATA_W-1:0] val;
        bit                       typed;
        ssps_pkg::status_t        want;
    } row_t;

    row_t directed_rows [24] = '{
        '{ssps_pkg::ACT_POP,      32'sd0,         1'b1, ssps_pkg::STAT_EMPTY},
        '{ssps_pkg::ACT_DUMP_FWD, 32'sd0,         1'b1, ssps_pkg::STAT_EMPTY},
        '{ssps_pkg::ACT_DUMP_REV, 32'sd0,         1'b1, ssps_pkg::STAT_EMPTY},
        '{ssps_pkg::ACT_SEARCH,   32'sd0,         1'b1, ssps_pkg::STAT_EMPTY},
        '{ssps_pkg::ACT_PUSH,     MAX_POS,        1'b1, ssps_pkg::STAT_DONE},
        '{ssps_pkg::ACT_PUSH,     MIN_NEG,        1'b1, ssps_pkg::STAT_DONE},
        '{ssps_pkg::ACT_PUSH,     32'sd0,         1'b0, ssps_pkg::STAT_DONE},
        '{ssps_pkg::ACT_PUSH,     ALL_ONE,        1'b0, ssps_pkg::STAT_DONE},
        '{ssps_pkg::ACT_PUSH,     MIN_NEG,        1'b0, ssps_pkg::STAT_DONE},
        '{ssps_pkg::ACT_SEARCH,   MIN_NEG,        1'b0, ssps_pkg::STAT_DONE},
        '{ssps_pkg::ACT_SEARCH,   MAX_POS,        1'b0, ssps_pkg::STAT_DONE},
        '{ssps_pkg::ACT_SEARCH,   32'sh1234_5678, 1'b0, ssps_pkg::STAT_DONE},
        '{ssps_pkg::ACT_DUMP_FWD, 32'sd0,         1'b0, ssps_pkg::STAT_DONE},
        '{ssps_pkg::ACT_DUMP_REV, 32'sd0,         1'b0, ssps_pkg::STAT_DONE},
        '{ACT_UNUSED_5,           ALL_ONE,        1'b0, ssps_pkg::STAT_DONE},
        '{ACT_UNUSED_6,           MIN_NEG,        1'b0, ssps_pkg::STAT_DONE},
        '{ACT_UNUSED_7,           MAX_POS,        1'b0, ssps_pkg::STAT_DONE},
        '{ssps_pkg::ACT_POP,      32'sd0,         1'b1, ssps_pkg::STAT_DONE},
        '{ssps_pkg::ACT_SEARCH,   MIN_NEG,        1'b0, ssps_pkg::STAT_DONE},
        '{ssps_pkg::ACT_POP,      ALL_ONE,        1'b0, ssps_pkg::STAT_DONE},
        '{ssps_pkg::ACT_POP,      32'sd0,         1'b0, ssps_pkg::STAT_DONE},
        '{ssps_pkg::ACT_POP,      32'sd0,         1'b0, ssps_pkg::STAT_DONE},
        '{ssps_pkg::ACT_DUMP_REV, 32'sd0,         1'b0, ssps_pkg::STAT_DONE},
        '{ssps_pkg::ACT_POP,      32'sd0,         1'b1, ssps_pkg::STAT_DONE}
    };

    // Shadow stack and the beats it still owes
    logic signed [DATA_W-1:0] shadow_store [DEPTH];
    int                       shadow_count;
    ssps_pkg::res_t           step_beats [$];
    ssps_pkg::res_t           due_beats [$];

    int                mismatch_count;
    int                counted_items;
    int                cycle_count;
    bit                steady;
    bit                hold_req;
    bit                row_typed;
    ssps_pkg::status_t row_want;

    sequence_store_push_pop_search #(
        .DEPTH (DEPTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .value         (value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .element_value (element_value),
        .position      (position),
        .last_flag     (last_flag)
    );

    always #5 clk = ~clk;

    function automatic ssps_pkg::res_t make_beat(input ssps_pkg::status_t st,
                                                 input logic signed [DATA_W-1:0] v,
                                                 input int pos, input bit last);
        ssps_pkg::res_t b;
        b.status = st;
        b.value  = v;
        b.pos    = pos[POS_W-1:0];
        b.last   = last;
        return b;
    endfunction

    // Apply one action to the shadow stack and list the beats it causes
    task automatic stack_op(input logic [ACT_W-1:0] act, input logic signed [DATA_W-1:0] v);
        int n;
        int hit;
        n = shadow_count;
        hit = 0;
        step_beats.delete();
        case (act)
            ssps_pkg::ACT_PUSH:
                if (n >= DEPTH)
                    step_beats.push_back(make_beat(ssps_pkg::STAT_FULL, 0, 0, 1'b1));
                else
                begin
                    shadow_store[n] = v;
                    shadow_count = n + 1;
                    step_beats.push_back(make_beat(ssps_pkg::STAT_DONE, 0, 0, 1'b1));
                end
            ssps_pkg::ACT_POP:
                if (n == 0)
                    step_beats.push_back(make_beat(ssps_pkg::STAT_EMPTY, 0, 0, 1'b1));
                else
                begin
                    shadow_count = n - 1;
                    step_beats.push_back(make_beat(ssps_pkg::STAT_DONE, 0, 0, 1'b1));
                end
            ssps_pkg::ACT_DUMP_FWD, ssps_pkg::ACT_DUMP_REV:
                if (n == 0)
                    step_beats.push_back(make_beat(ssps_pkg::STAT_EMPTY, 0, 0, 1'b1));
                else if (act == ssps_pkg::ACT_DUMP_FWD)
                    for (int i = 0; i < n; i++)
                        step_beats.push_back(make_beat(ssps_pkg::STAT_LISTED,
                                                       shadow_store[i], i + 1,
                                                       i == n - 1));
                else
                    for (int i = n - 1; i >= 0; i--)
                        step_beats.push_back(make_beat(ssps_pkg::STAT_LISTED,
                                                       shadow_store[i], i + 1,
                                                       i == 0));
            ssps_pkg::ACT_SEARCH:
                if (n == 0)
                    step_beats.push_back(make_beat(ssps_pkg::STAT_EMPTY, 0, 0, 1'b1));
                else
                begin
                    // first match from the head wins
                    for (int i = 0; i < n; i++)
                        if (hit == 0 && shadow_store[i] == v)
                            hit = i + 1;
                    if (hit != 0)
                        step_beats.push_back(make_beat(ssps_pkg::STAT_FOUND, 0, hit, 1'b1));
                    else
                        step_beats.push_back(make_beat(ssps_pkg::STAT_NOT_FOUND, 0, 0,
                                                       1'b1));
                end
            default:
                ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("[%0t] mismatch on %s: got %h, want %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Check result beats and predict on accepted input beats
    always @(posedge clk)
    begin
        ssps_pkg::res_t exp_beat;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (due_beats.size() == 0)
                    report_mismatch("beat with nothing due", {29'd0, status}, 0);
                else
                begin
                    exp_beat = due_beats.pop_front();
                    if (status !== exp_beat.status)
                        report_mismatch("status", {29'd0, status}, {29'd0, exp_beat.status});
                    if (element_value !== exp_beat.value)
                        report_mismatch("element_value", element_value, exp_beat.value);
                    if (position !== exp_beat.pos)
                        report_mismatch("position", {25'd0, position}, {25'd0, exp_beat.pos});
                    if (last_flag !== exp_beat.last)
                        report_mismatch("last_flag", {31'd0, last_flag},
                                        {31'd0, exp_beat.last});
                end
            end
            if (in_valid && in_ready)
            begin
                stack_op(action, value);
                if (row_typed)
                    due_beats.push_back(make_beat(row_want, 0, 0, 1'b1));
                else
                    foreach (step_beats[k])
                        due_beats.push_back(step_beats[k]);
            end
        end
    end

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 3))
            0, 1:    return $urandom;
            2:       return $signed($urandom_range(0, 7)) - 4;
            default:
                case ($urandom_range(0, 3))
                    0:       return MAX_POS;
                    1:       return MIN_NEG;
                    2:       return ALL_ONE;
                    default: return 32'sd0;
                endcase
        endcase
    endfunction

    // Offer one input beat and hold it until accepted
    task automatic send_item(input logic [ACT_W-1:0] act, input logic signed [DATA_W-1:0] v,
                             input bit pick_stored, input bit typed,
                             input ssps_pkg::status_t want);
        logic signed [DATA_W-1:0] v_eff;
        v_eff = v;
        steady = (counted_items >= 40 && counted_items < 100);
        if (counted_items >= 200)
            hold_req = 1'b1;
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < 33)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        // search for a value that is really stored
        if (pick_stored && shadow_count > 0)
            v_eff = shadow_store[$urandom_range(0, shadow_count - 1)];
        row_typed = typed;
        row_want  = want;
        in_valid <= 1'b1;
        action   <= act;
        value    <= v_eff;
        do
            @(posedge clk);
        while (!in_ready);
        if (act <= ssps_pkg::ACT_SEARCH)
            counted_items++;
    endtask

    task automatic send_plain(input logic [ACT_W-1:0] act, input logic signed [DATA_W-1:0] v);
        send_item(act, v, 1'b0, 1'b0, ssps_pkg::STAT_DONE);
    endtask

    // Random rounds of well-formed bursts, queries and noise
    task automatic run_random();
        int burst;
        send_plain(ssps_pkg::ACT_DUMP_FWD, pick_value());
        for (int i = 0; i < DEPTH + 2; i++)
            send_plain(ssps_pkg::ACT_PUSH, pick_value());
        send_plain(ssps_pkg::ACT_DUMP_FWD, pick_value());
        send_plain(ssps_pkg::ACT_DUMP_REV, pick_value());
        send_item(ssps_pkg::ACT_SEARCH, 0, 1'b1, 1'b0, ssps_pkg::STAT_DONE);
        send_plain(ssps_pkg::ACT_SEARCH, pick_value());
        for (int i = 0; i < DEPTH + 1; i++)
            send_plain(ssps_pkg::ACT_POP, pick_value());
        while (counted_items < TOTAL_ITEMS)
        begin
            burst = $urandom_range(1, 12);
            case ($urandom_range(0, 9))
                0, 1, 2:
                    for (int i = 0; i < 3 * burst; i++)
                        send_plain(ssps_pkg::ACT_PUSH, pick_value());
                3, 4:
                    for (int i = 0; i < 2 * burst; i++)
                        send_plain(ssps_pkg::ACT_POP, pick_value());
                5, 6:
                    for (int i = 0; i < burst; i++)
                        case ($urandom_range(0, 3))
                            0:       send_plain(ssps_pkg::ACT_DUMP_FWD, pick_value());
                            1:       send_plain(ssps_pkg::ACT_DUMP_REV, pick_value());
                            2:       send_item(ssps_pkg::ACT_SEARCH, 0, 1'b1, 1'b0,
                                               ssps_pkg::STAT_DONE);
                            default: send_plain(ssps_pkg::ACT_SEARCH, pick_value());
                        endcase
                7, 8:
                    for (int i = 0; i < burst; i++)
                        send_item(3'($urandom_range(ssps_pkg::ACT_PUSH, ssps_pkg::ACT_SEARCH)),
                                  pick_value(), 1'($urandom_range(0, 1)), 1'b0,
                                  ssps_pkg::STAT_DONE);
                default:
                    for (int i = 0; i < burst; i++)
                        send_plain(3'($urandom_range(0, 7)), $urandom);
            endcase
        end
    endtask

    // Result side: random back-pressure plus one long hold-off
    initial
    begin
        bit held;
        held = 1'b0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req && !held)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                held = 1'b1;
            end
            else if (steady)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 99) >= 33);
        end
    end

    // Watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = ssps_pkg::ACT_PUSH;
        value = '0;
        shadow_count = 0;
        mismatch_count = 0;
        counted_items = 0;
        steady = 1'b0;
        hold_req = 1'b0;
        row_typed = 1'b0;
        row_want = ssps_pkg::STAT_DONE;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[r])
            send_item(directed_rows[r].act, directed_rows[r].val, 1'b0,
                      directed_rows[r].typed, directed_rows[r].want);
        run_random();

        // drop valid, drain what is owed, then watch for stray beats
        @(negedge clk);
        in_valid <= 1'b0;
        wait (due_beats.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
